// File: hdl/dfog_pkg.sv
package dfog_pkg;

    localparam int DIST_W   = 24;
    localparam int CFG_W    = 24;
    localparam int ARG_FRAC = 24;
    localparam int PROD_W   = 48;

    // ln 2 in Q.32
    localparam logic [31:0] LN2_Q32 = 32'd2977044472;
    localparam int TAYLOR_TERMS = 12;

    localparam logic [2:0] REG_MODE    = 3'd0;
    localparam logic [2:0] REG_START   = 3'd1;
    localparam logic [2:0] REG_END     = 3'd2;
    localparam logic [2:0] REG_DENSITY = 3'd3;
    localparam logic [2:0] REG_COLOUR  = 3'd4;

    typedef enum logic [1:0] {
        MODE_NONE   = 2'd0,
        MODE_LINEAR = 2'd1,
        MODE_EXP    = 2'd2,
        MODE_EXP2   = 2'd3
    } t_fog_mode;

    // where the final factor comes from
    typedef enum logic [1:0] {
        FK_ONE  = 2'd0,
        FK_ZERO = 2'd1,
        FK_LIN  = 2'd2,
        FK_EXP  = 2'd3
    } t_fkind;

    typedef struct packed {
        t_fkind kind;
        logic   sq;
    } t_fctl;

endpackage

// File: hdl/dfog_lin_div.sv
module dfog_lin_div
    import dfog_pkg::*;
#(
    parameter int FRAC = 15,
    parameter int SW   = 1,
    localparam int NW  = DIST_W + FRAC + 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_vld,
    input  logic [NW-1:0]     i_num,
    input  logic [DIST_W-1:0] i_den,
    input  logic [SW-1:0]     i_side,
    output logic              o_vld,
    output logic [FRAC:0]     o_quo,
    output logic [SW-1:0]     o_side
);

    localparam int NS = FRAC + 1;
    localparam int RW = DIST_W + 1;

    logic              r_vld  [NS];
    logic [DIST_W-1:0] r_rem  [NS];
    logic [FRAC:0]     r_quo  [NS];
    logic [NW-1:0]     r_num  [NS];
    logic [DIST_W-1:0] r_den  [NS];
    logic [SW-1:0]     r_side [NS];

    // restoring division, one quotient bit per stage, MSB first
    for (genvar k = 0; k < NS; k++) begin : g_stage
        logic              vld_in;
        logic [DIST_W-1:0] rem_in;
        logic [FRAC:0]     quo_in;
        logic [NW-1:0]     num_in;
        logic [DIST_W-1:0] den_in;
        logic [SW-1:0]     side_in;
        logic [RW-1:0]     trial;
        logic [RW-1:0]     diff;
        logic              take;

        if (k == 0) begin : g_first
            assign vld_in  = i_vld;
            assign rem_in  = i_num[NW-1 -: DIST_W];
            assign quo_in  = '0;
            assign num_in  = i_num;
            assign den_in  = i_den;
            assign side_in = i_side;
        end else begin : g_next
            assign vld_in  = r_vld[k-1];
            assign rem_in  = r_rem[k-1];
            assign quo_in  = r_quo[k-1];
            assign num_in  = r_num[k-1];
            assign den_in  = r_den[k-1];
            assign side_in = r_side[k-1];
        end

        assign trial = {rem_in, num_in[FRAC-k]};
        assign diff  = trial - {1'b0, den_in};
        assign take  = trial >= {1'b0, den_in};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= take ? diff[DIST_W-1:0] : trial[DIST_W-1:0];
                r_quo[k]  <= {quo_in[FRAC-1:0], take};
                r_num[k]  <= num_in;
                r_den[k]  <= den_in;
                r_side[k] <= side_in;
            end
        end
    end

    assign o_vld  = r_vld[NS-1];
    assign o_quo  = r_quo[NS-1];
    assign o_side = r_side[NS-1];

endmodule

// File: hdl/dfog_exp.sv
module dfog_exp
    import dfog_pkg::*;
#(
    parameter int FRAC = 15,
    parameter int SW   = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_vld,
    input  logic [PROD_W-1:0] i_x,
    input  logic              i_sq,
    input  logic [SW-1:0]     i_side,
    output logic              o_vld,
    output logic [FRAC:0]     o_f,
    output logic [SW-1:0]     o_side
);

    localparam int XW   = ARG_FRAC + 3;          // x below 8.0
    localparam int SQW  = 2 * XW;
    localparam int AMW  = ARG_FRAC + 5;          // a below 32.0
    localparam int A32W = AMW + 32 - ARG_FRAC;
    localparam int ND   = 6;                     // bits of n
    localparam int NT   = TAYLOR_TERMS - 1;
    localparam int TS   = 3 * NT;
    localparam int ACW  = 34;
    localparam int LAT  = 2 + ND + TS + 3;
    localparam logic [6:0] SBASE = 7'(32 - FRAC);

    logic          r_vld  [LAT];
    logic [SW-1:0] r_side [LAT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LAT; i++) r_vld[i] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_vld;
            for (int i = 1; i < LAT; i++) r_vld[i] <= r_vld[i-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= i_side;
            for (int i = 1; i < LAT; i++) r_side[i] <= r_side[i-1];
        end
    end

    // argument: square for exp2, then range check
    logic              r1_sq;
    logic              r1_big3;
    logic [PROD_W-1:0] r1_x;
    logic [SQW-1:0]    r1_sqr;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_sq   <= i_sq;
            r1_big3 <= |i_x[PROD_W-1:XW];
            r1_x    <= i_x;
            r1_sqr  <= SQW'(i_x[XW-1:0]) * SQW'(i_x[XW-1:0]);
        end
    end

    logic [SQW-1:0]    a_sq;
    logic [PROD_W-1:0] a_full;
    logic [AMW-1:0]    r2_a;
    logic              r2_big;

    assign a_sq   = (r1_sqr + (SQW'(1) << (ARG_FRAC - 1))) >> ARG_FRAC;
    assign a_full = r1_sq ? PROD_W'(a_sq) : r1_x;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_a   <= a_full[AMW-1:0];
            r2_big <= (r1_sq & r1_big3) | (|a_full[PROD_W-1:AMW]);
        end
    end

    // a = n*ln2 + r
    logic [A32W-1:0] r_drem [ND];
    logic [ND-1:0]   r_dn   [ND];
    logic            r_dbig [ND];

    for (genvar j = 0; j < ND; j++) begin : g_div
        localparam logic [A32W-1:0] DSTEP = A32W'(LN2_Q32) << (ND - 1 - j);
        logic [A32W-1:0] rem_in;
        logic [ND-1:0]   n_in;
        logic            big_in;
        logic            take;

        if (j == 0) begin : g_first
            assign rem_in = {r2_a, {(32 - ARG_FRAC){1'b0}}};
            assign n_in   = '0;
            assign big_in = r2_big;
        end else begin : g_next
            assign rem_in = r_drem[j-1];
            assign n_in   = r_dn[j-1];
            assign big_in = r_dbig[j-1];
        end

        assign take = rem_in >= DSTEP;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_drem[j] <= take ? rem_in - DSTEP : rem_in;
                r_dn[j]   <= {n_in[ND-2:0], take};
                r_dbig[j] <= big_in;
            end
        end
    end

    // Taylor series of exp(-r), three stages a term:
    // multiply by r, divide by k via reciprocal, correct by one
    logic [ACW-1:0] r_tacc [TS];
    logic [31:0]    r_tr   [TS];
    logic [ND-1:0]  r_tn   [TS];
    logic           r_tbig [TS];
    logic [31:0]    r_tv   [TS];
    logic [31:0]    r_tq   [NT];

    for (genvar j = 0; j < NT; j++) begin : g_term
        localparam int K = j + 2;
        localparam logic [31:0] RECIP = 32'((64'd1 << 32) / K);
        localparam int SA = 3 * j;
        localparam int SB = 3 * j + 1;
        localparam int SC = 3 * j + 2;

        logic [31:0]    term_in;
        logic [ACW-1:0] acc_in;
        logic [ACW-1:0] acc_nxt;
        logic [31:0]    r_in;
        logic [ND-1:0]  n_in;
        logic           big_in;
        logic [63:0]    prod;
        logic [63:0]    qprod;
        logic [31:0]    rem;

        if (j == 0) begin : g_first
            assign term_in = r_drem[ND-1][31:0];
            assign r_in    = r_drem[ND-1][31:0];
            assign n_in    = r_dn[ND-1];
            assign big_in  = r_dbig[ND-1];
            assign acc_in  = ACW'(1) << 32;
            assign acc_nxt = acc_in - ACW'(term_in);
        end else begin : g_next
            assign term_in = r_tv[SA-1];
            assign r_in    = r_tr[SA-1];
            assign n_in    = r_tn[SA-1];
            assign big_in  = r_tbig[SA-1];
            assign acc_in  = r_tacc[SA-1];
            // previous term has index j+1: odd terms subtract
            if (j % 2 == 0) begin : g_sub
                assign acc_nxt = acc_in - ACW'(term_in);
            end else begin : g_add
                assign acc_nxt = acc_in + ACW'(term_in);
            end
        end

        assign prod  = 64'(term_in) * 64'(r_in);
        assign qprod = 64'(r_tv[SA]) * 64'(RECIP);
        assign rem   = r_tv[SB] - 32'(r_tq[j] * 32'(K));

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_tv[SA]   <= prod[63:32];
                r_tacc[SA] <= acc_nxt;
                r_tr[SA]   <= r_in;
                r_tn[SA]   <= n_in;
                r_tbig[SA] <= big_in;

                r_tq[j]    <= qprod[63:32];
                r_tv[SB]   <= r_tv[SA];
                r_tacc[SB] <= r_tacc[SA];
                r_tr[SB]   <= r_tr[SA];
                r_tn[SB]   <= r_tn[SA];
                r_tbig[SB] <= r_tbig[SA];

                r_tv[SC]   <= (rem >= 32'(K)) ? r_tq[j] + 32'd1 : r_tq[j];
                r_tacc[SC] <= r_tacc[SB];
                r_tr[SC]   <= r_tr[SB];
                r_tn[SC]   <= r_tn[SB];
                r_tbig[SC] <= r_tbig[SB];
            end
        end
    end

    // last term is even, then scale by 2^-n and round
    logic [ACW-1:0] r_f1_e;
    logic [6:0]     r_f1_s;
    logic           r_f1_big;
    logic [63:0]    r_f2_sum;
    logic [5:0]     r_f2_s;
    logic           r_f2_zero;
    logic [FRAC:0]  r_f3;
    logic [63:0]    shifted;

    assign shifted = r_f2_sum >> r_f2_s;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_f1_e    <= r_tacc[TS-1] + ACW'(r_tv[TS-1]);
            r_f1_s    <= SBASE + 7'(r_tn[TS-1]);
            r_f1_big  <= r_tbig[TS-1];

            r_f2_sum  <= 64'(r_f1_e) + (64'd1 << (r_f1_s - 7'd1));
            r_f2_s    <= r_f1_s[5:0];
            r_f2_zero <= r_f1_big | (r_f1_s > 7'd63);

            r_f3      <= r_f2_zero ? '0 : shifted[FRAC:0];
        end
    end

    assign o_vld  = r_vld[LAT-1];
    assign o_side = r_side[LAT-1];
    assign o_f    = r_f3;

endmodule

// File: hdl/dfog_mix.sv
module dfog_mix
    import dfog_pkg::*;
#(
    parameter int CB     = 8,
    parameter int FRAC   = 15,
    localparam int RGB_W = 3 * CB
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_vld,
    input  t_fkind           i_kind,
    input  logic [FRAC:0]    i_quo,
    input  logic [FRAC:0]    i_fexp,
    input  logic [RGB_W-1:0] i_fog,
    input  logic [RGB_W-1:0] i_surf,
    output logic             o_vld,
    output logic [RGB_W-1:0] o_rgb,
    output logic [FRAC:0]    o_vis
);

    localparam int PW = CB + FRAC + 1;
    localparam logic [FRAC:0] ONE  = {1'b1, {FRAC{1'b0}}};
    localparam logic [PW:0]   HALF = (PW + 1)'(1) << (FRAC - 1);

    logic             r1_vld;
    logic             r2_vld;
    logic             r3_vld;
    logic [FRAC:0]    n1_f;
    logic [FRAC:0]    r1_f;
    logic [FRAC:0]    r1_g;
    logic [RGB_W-1:0] r1_fog;
    logic [RGB_W-1:0] r1_surf;
    logic [FRAC:0]    r2_f;
    logic [FRAC:0]    r3_f;
    logic [PW-1:0]    r2_pf [3];
    logic [PW-1:0]    r2_ps [3];
    logic [RGB_W-1:0] r3_rgb;

    always_comb begin
        case (i_kind)
            FK_ONE:  n1_f = ONE;
            FK_ZERO: n1_f = '0;
            FK_LIN:  n1_f = i_quo;
            FK_EXP:  n1_f = i_fexp;
            default: n1_f = ONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
        end else if (i_en) begin
            r1_vld <= i_vld;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_f    <= n1_f;
            r1_g    <= ONE - n1_f;
            r1_fog  <= i_fog;
            r1_surf <= i_surf;
            r2_f    <= r1_f;
            r3_f    <= r2_f;
        end
    end

    // lane 0 is red; fog colour holds red in its top bits
    for (genvar l = 0; l < 3; l++) begin : g_lane
        logic [PW:0] sum;

        assign sum = (PW + 1)'(r2_pf[l]) + (PW + 1)'(r2_ps[l]) + HALF;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r2_pf[l] <= PW'(r1_fog[(2 - l) * CB +: CB]) * PW'(r1_g);
                r2_ps[l] <= PW'(r1_surf[l * CB +: CB]) * PW'(r1_f);
                r3_rgb[l * CB +: CB] <= sum[FRAC +: CB];
            end
        end
    end

    assign o_vld = r3_vld;
    assign o_rgb = r3_rgb;
    assign o_vis = r3_f;

endmodule

// File: hdl/distance_fog_factor_blend.sv
// Distance fog, one pixel per clock unless stalled.
// In order: capture, classify, divider, exp unit, colour mix, output register;
// the linear divider gives one quotient bit per stage and the exp unit spends three
// stages on each Taylor term. A two-entry output buffer absorbs back-pressure.
// Throughput: one item per cycle unless the full skid slot stalls the pipeline.
// Reset (synchronous, active low) clears all valid bits and the config registers.
module distance_fog_factor_blend
    import dfog_pkg::*;
#(
    parameter int COLOUR_BITS      = 8,
    parameter int FACTOR_FRAC_BITS = 15,
    localparam int RGB_W = 3 * COLOUR_BITS,
    localparam int IW    = ((DIST_W + RGB_W + 7) / 8) * 8,
    localparam int OW    = ((RGB_W + FACTOR_FRAC_BITS + 1 + 7) / 8) * 8,
    localparam int DW    = (RGB_W > 32) ? 64 : 32,
    localparam int AW    = (RGB_W > 32) ? 6 : 5
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // view_distance, surface_red, surface_green, surface_blue
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [IW-1:0] s_axis_tdata,
    // out_red, out_green, out_blue, visibility
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [OW-1:0] m_axis_tdata,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [AW-1:0] paddr,
    input  logic [DW-1:0] pwdata,
    output logic [DW-1:0] prdata,
    output logic          pready
);

    localparam int F     = FACTOR_FRAC_BITS;
    localparam int NW    = DIST_W + F + 1;
    localparam int CTL_W = $bits(t_fctl);
    localparam int SW1   = RGB_W + CTL_W + PROD_W;
    localparam int SW2   = RGB_W + 2 + F + 1;
    localparam logic [F:0] ONE = {1'b1, {F{1'b0}}};

    // configuration
    t_fog_mode        r_mode;
    logic [CFG_W-1:0] r_start;
    logic [CFG_W-1:0] r_end;
    logic [CFG_W-1:0] r_density;
    logic [RGB_W-1:0] r_colour;
    logic [2:0]       reg_idx;
    logic             cfg_wr;

    assign reg_idx = paddr[AW-1 -: 3];
    assign cfg_wr  = psel & penable & pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_NONE;
            r_start   <= '0;
            r_end     <= '0;
            r_density <= '0;
            r_colour  <= '0;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_MODE:    r_mode    <= t_fog_mode'(pwdata[1:0]);
                REG_START:   r_start   <= pwdata[CFG_W-1:0];
                REG_END:     r_end     <= pwdata[CFG_W-1:0];
                REG_DENSITY: r_density <= pwdata[CFG_W-1:0];
                REG_COLOUR:  r_colour  <= pwdata[RGB_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_MODE:    prdata = DW'(r_mode);
            REG_START:   prdata = DW'(r_start);
            REG_END:     prdata = DW'(r_end);
            REG_DENSITY: prdata = DW'(r_density);
            REG_COLOUR:  prdata = DW'(r_colour);
            default:     prdata = '0;
        endcase
    end

    // whole pipeline moves while the skid slot is free
    logic r_out_vld;
    logic r_skid_vld;
    logic en;

    assign en            = !r_skid_vld;
    assign s_axis_tready = en;

    // stage 1: capture
    logic              r1_vld;
    logic [DIST_W-1:0] r1_d;
    logic [RGB_W-1:0]  r1_rgb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (en) begin
            r1_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_d   <= s_axis_tdata[DIST_W-1:0];
            r1_rgb <= s_axis_tdata[DIST_W +: RGB_W];
        end
    end

    // stage 2: classify, linear numerator, density * distance
    logic [CFG_W-1:0]  span;
    logic [CFG_W-1:0]  ldiff;
    t_fctl             n2_ctl;
    logic              r2_vld;
    t_fctl             r2_ctl;
    logic [NW-1:0]     r2_num;
    logic [CFG_W-1:0]  r2_span;
    logic [PROD_W-1:0] r2_x;
    logic [RGB_W-1:0]  r2_rgb;

    assign span  = r_end - r_start;
    assign ldiff = r_end - r1_d;

    always_comb begin
        n2_ctl.sq = (r_mode == MODE_EXP2);
        if (r_mode == MODE_NONE || r1_d == '0) begin
            n2_ctl.kind = FK_ONE;
        end else if (r_mode == MODE_LINEAR) begin
            if (r_end <= r_start || r1_d <= r_start) begin
                n2_ctl.kind = FK_ONE;
            end else if (r1_d >= r_end) begin
                n2_ctl.kind = FK_ZERO;
            end else begin
                n2_ctl.kind = FK_LIN;
            end
        end else begin
            n2_ctl.kind = FK_EXP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (en) begin
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_ctl  <= n2_ctl;
            r2_num  <= (NW'(ldiff) << F) + NW'(span >> 1);
            r2_span <= span;
            r2_x    <= PROD_W'(r_density) * PROD_W'(r1_d);
            r2_rgb  <= r1_rgb;
        end
    end

    // linear divider
    logic           d_vld;
    logic [F:0]     d_quo;
    logic [SW1-1:0] d_side;
    t_fctl          d_ctl;

    dfog_lin_div #(
        .FRAC (F),
        .SW   (SW1)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r2_vld),
        .i_num   (r2_num),
        .i_den   (r2_span),
        .i_side  ({r2_rgb, r2_ctl, r2_x}),
        .o_vld   (d_vld),
        .o_quo   (d_quo),
        .o_side  (d_side)
    );

    assign d_ctl = t_fctl'(d_side[PROD_W +: CTL_W]);

    // exponential unit
    logic           e_vld;
    logic [F:0]     e_f;
    logic [SW2-1:0] e_side;

    dfog_exp #(
        .FRAC (F),
        .SW   (SW2)
    ) u_exp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (d_vld),
        .i_x     (d_side[PROD_W-1:0]),
        .i_sq    (d_ctl.sq),
        .i_side  ({d_side[PROD_W + CTL_W +: RGB_W], d_ctl.kind, d_quo}),
        .o_vld   (e_vld),
        .o_f     (e_f),
        .o_side  (e_side)
    );

    // colour mix
    logic             m_vld;
    logic [RGB_W-1:0] m_rgb;
    logic [F:0]       m_vis;

    dfog_mix #(
        .CB   (COLOUR_BITS),
        .FRAC (F)
    ) u_mix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (e_vld),
        .i_kind  (t_fkind'(e_side[F+1 +: 2])),
        .i_quo   (e_side[F:0]),
        .i_fexp  (e_f),
        .i_fog   (r_colour),
        .i_surf  (e_side[F+3 +: RGB_W]),
        .o_vld   (m_vld),
        .o_rgb   (m_rgb),
        .o_vis   (m_vis)
    );

    // output register plus skid slot
    logic [OW-1:0] r_out_data;
    logic [OW-1:0] r_skid_data;
    logic [OW-1:0] new_data;

    assign new_data = OW'({m_vis, m_rgb});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (m_axis_tready) begin
                r_skid_vld <= 1'b0;
            end
        end else if (m_vld) begin
            if (!r_out_vld || m_axis_tready) begin
                r_out_vld <= 1'b1;
            end else begin
                r_skid_vld <= 1'b1;
            end
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_vld) begin
            if (m_axis_tready) begin
                r_out_data <= r_skid_data;
            end
        end else if (m_vld) begin
            if (!r_out_vld || m_axis_tready) begin
                r_out_data <= new_data;
            end else begin
                r_skid_data <= new_data;
            end
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;

`ifndef SYNTHESIS
    a_skid_implies_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld)
        else $error("skid slot full with empty output register");

    a_vis_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (r_out_data[RGB_W +: F+1] <= ONE))
        else $error("visibility above full scale");

    a_skid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_vld && !m_axis_tready) |=> (r_skid_vld && $stable(r_skid_data)))
        else $error("skid entry lost while output stalled");
`endif

endmodule

// File: bench/distance_fog_factor_blend_tb.sv
`timescale 1ns / 100ps

module distance_fog_factor_blend_tb
    import dfog_pkg::*;
();

    localparam int CB = 8;
    localparam int FB = 15;
    localparam int IW = 48;
    localparam int OW = 40;
    localparam logic [63:0] ONE_F = 64'd1 << FB;
    localparam int LATENCY = FB + 50;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int LONG_HOLD = 300;

    typedef struct packed {
        logic [CB-1:0] blue;
        logic [CB-1:0] green;
        logic [CB-1:0] red;
        logic [23:0]   view_d;
    } t_pixel;

    typedef struct packed {
        logic [FB:0]   vis;
        logic [CB-1:0] blue;
        logic [CB-1:0] green;
        logic [CB-1:0] red;
    } t_fogged;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          s_axis_tvalid = 1'b0;
    logic          s_axis_tready;
    logic [IW-1:0] s_axis_tdata = '0;
    logic          m_axis_tvalid;
    logic          m_axis_tready = 1'b0;
    logic [OW-1:0] m_axis_tdata;
    logic          psel = 1'b0;
    logic          penable = 1'b0;
    logic          pwrite = 1'b0;
    logic [4:0]    paddr = '0;
    logic [31:0]   pwdata = '0;
    logic [31:0]   prdata;
    logic          pready;

    distance_fog_factor_blend uut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor copy of the configuration
    t_fog_mode   cfg_mode;
    logic [23:0] cfg_start, cfg_end, cfg_density, cfg_colour;

    t_pixel  pixel_q[$];
    t_fogged fogged_q[$];
    int      fail_count = 0;
    int      idle_cycles = 0;
    bit      sink_hold = 1'b0;
    bit      src_pause = 1'b0;
    bit      in_stuck = 1'b0;
    int      hold_count = 0;
    int      gap_left = 0;

    function automatic logic [63:0] neg_exp_q(logic [63:0] a);
        logic [63:0] a32, n, r, term, pos, neg, e, s;
        if (a >= (64'd32 << ARG_FRAC))
            return 0;
        a32 = a << (32 - ARG_FRAC);
        n = a32 / LN2_Q32;
        r = a32 - n * LN2_Q32;
        term = 64'd1 << 32;
        pos = term;
        neg = 0;
        for (int k = 1; k <= TAYLOR_TERMS; k++) begin
            term = ((term * r) >> 32) / k;
            if (k % 2) neg += term;
            else pos += term;
        end
        e = pos - neg;
        s = 32 - FB + n;
        if (s > 63)
            return 0;
        return (e + (64'd1 << (s - 1))) >> s;
    endfunction

    function automatic logic [63:0] visibility_of(logic [63:0] d);
        logic [63:0] span, x;
        if (cfg_mode == MODE_NONE || d == 0)
            return ONE_F;
        if (cfg_mode == MODE_LINEAR) begin
            if (cfg_end <= cfg_start || d <= cfg_start)
                return ONE_F;
            if (d >= cfg_end)
                return 0;
            span = 64'(cfg_end) - 64'(cfg_start);
            return (((64'(cfg_end) - d) << FB) + span / 2) / span;
        end
        x = 64'(cfg_density) * d;
        if (cfg_mode == MODE_EXP)
            return neg_exp_q(x);
        if (x >= (64'd8 << ARG_FRAC))
            return 0;
        return neg_exp_q((x * x + (64'd1 << (ARG_FRAC - 1))) >> ARG_FRAC);
    endfunction

    function automatic logic [CB-1:0] blend(logic [63:0] fog, logic [63:0] surf,
                                            logic [63:0] f);
        logic [63:0] v;
        v = fog * (ONE_F - f) + surf * f + (ONE_F >> 1);
        return CB'(v >> FB);
    endfunction

    function automatic t_fogged fog_pixel(t_pixel p);
        t_fogged o;
        logic [63:0] f;
        f = visibility_of(64'(p.view_d));
        o.red   = blend(64'(cfg_colour[23:16]), 64'(p.red), f);
        o.green = blend(64'(cfg_colour[15:8]), 64'(p.green), f);
        o.blue  = blend(64'(cfg_colour[7:0]), 64'(p.blue), f);
        o.vis   = f[FB:0];
        return o;
    endfunction

    // a transaction still waiting for acceptance after the last rising edge
    always @(posedge i_clk) begin
        in_stuck <= s_axis_tvalid && !s_axis_tready;
    end

    // driver: short gaps mostly, occasionally long
    always @(negedge i_clk) begin
        if (i_rst_n && !in_stuck) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                s_axis_tvalid <= 1'b0;
            end else if (pixel_q.size() > 0 && !src_pause && $urandom_range(0, 3) != 0) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= pixel_q.pop_front();
                if ($urandom_range(0, 49) == 0)
                    gap_left <= $urandom_range(10, 30);
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // sink stalls: short mostly, occasionally long
    int stall_left = 0;
    always @(negedge i_clk) begin
        if (sink_hold && hold_count < LONG_HOLD) begin
            hold_count <= hold_count + 1;
            m_axis_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            case ($urandom_range(0, 19))
                0, 1, 2: stall_left <= $urandom_range(1, 3);
                3:       stall_left <= $urandom_range(10, 40);
                default: ;
            endcase
        end
    end

    // monitor: prediction on input acceptance, check on output acceptance
    always @(posedge i_clk) begin
        t_fogged got, want;
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (s_axis_tvalid && s_axis_tready) begin
                fogged_q.push_back(fog_pixel(t_pixel'(s_axis_tdata)));
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got = t_fogged'(m_axis_tdata);
                if (fogged_q.size() == 0) begin
                    $error("unexpected result %h", m_axis_tdata);
                    fail_count++;
                end else begin
                    want = fogged_q.pop_front();
                    if (got.red !== want.red) begin
                        $error("out_red exp %0d got %0d", want.red, got.red);
                        fail_count++;
                    end
                    if (got.green !== want.green) begin
                        $error("out_green exp %0d got %0d", want.green, got.green);
                        fail_count++;
                    end
                    if (got.blue !== want.blue) begin
                        $error("out_blue exp %0d got %0d", want.blue, got.blue);
                        fail_count++;
                    end
                    if (got.vis !== want.vis) begin
                        $error("visibility exp %0d got %0d", want.vis, got.vis);
                        fail_count++;
                    end
                end
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("distance_fog_factor_blend_tb: FAIL");
                $finish;
            end
        end
    end

    task automatic reg_write(logic [2:0] idx, logic [31:0] val);
        @(negedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= {idx, 2'b00}; pwdata <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            REG_MODE:    cfg_mode    = t_fog_mode'(val[1:0]);
            REG_START:   cfg_start   = val[23:0];
            REG_END:     cfg_end     = val[23:0];
            REG_DENSITY: cfg_density = val[23:0];
            default:     cfg_colour  = val[23:0];
        endcase
    endtask

    task automatic drain();
        while (pixel_q.size() > 0 || s_axis_tvalid || fogged_q.size() > 0)
            @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    function automatic t_pixel rand_pixel(logic [23:0] d);
        t_pixel p;
        p.view_d = d;
        p.red = CB'($urandom); p.green = CB'($urandom); p.blue = CB'($urandom);
        return p;
    endfunction

    // distances clustered around the interesting range of the current setting
    function automatic logic [23:0] rand_dist();
        case ($urandom_range(0, 5))
            0: return 24'($urandom);
            1: return 24'($urandom_range(0, 16));
            2: return 24'(cfg_start + $urandom_range(0, 3) - 1);
            3: return 24'(cfg_end + $urandom_range(0, 3) - 1);
            default: return 24'($urandom_range(cfg_start,
                                               cfg_end > cfg_start ? cfg_end : cfg_start));
        endcase
    endfunction

    initial begin
        logic [23:0] dirs[6] = '{24'd0, 24'd1, 24'd256, 24'h7FFFFF, 24'hFFFFFE, 24'hFFFFFF};
        cfg_mode = MODE_NONE;
        cfg_start = 0; cfg_end = 0; cfg_density = 0; cfg_colour = 0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: each mode with extreme fields
        for (int m = 0; m < 4; m++) begin
            reg_write(REG_MODE, 32'(m));
            reg_write(REG_START, 32'd1000);
            reg_write(REG_END, m == 1 ? 32'h00FFFFFF : 32'd5000);
            reg_write(REG_DENSITY, m == 3 ? 32'h00000100 : 32'h00000400);
            reg_write(REG_COLOUR, m[0] ? 32'h00FFFFFF : 32'h0000FF80);
            foreach (dirs[i]) begin
                pixel_q.push_back('{blue: 8'hFF, green: 8'h00, red: 8'hFF, view_d: dirs[i]});
            end
            drain();
        end
        // linear with end below start: a distance between the two, then a small one
        reg_write(REG_MODE, 32'(MODE_LINEAR));
        reg_write(REG_START, 32'd5000);
        reg_write(REG_END, 32'd4000);
        pixel_q.push_back(rand_pixel(24'd4500));
        pixel_q.push_back(rand_pixel(24'd10));
        drain();

        // random phases across settings
        for (int ph = 0; ph < 26; ph++) begin
            logic [23:0] a, b;
            a = $urandom_range(0, 3) == 0 ? 24'(ph[0] ? 24'hFFFFFF : 0) : 24'($urandom);
            b = 24'($urandom);
            if ($urandom_range(0, 1)) a = a >> $urandom_range(0, 16);
            reg_write(REG_MODE, $urandom);
            reg_write(REG_START, 32'(a < b ? a : b));
            reg_write(REG_END, 32'(a < b ? b : a));
            case ($urandom_range(0, 4))
                0: reg_write(REG_DENSITY, 32'h00FFFFFF);
                1: reg_write(REG_DENSITY, 32'd0);
                default: reg_write(REG_DENSITY,
                                   $urandom_range(1, 32'h4000) >> $urandom_range(0, 10));
            endcase
            reg_write(REG_COLOUR, $urandom);
            for (int i = 0; i < 75; i++) begin
                logic [23:0] d;
                d = rand_dist();
                // exp modes: keep many arguments below saturation
                if (cfg_mode >= MODE_EXP && $urandom_range(0, 1))
                    d = d >> $urandom_range(4, 20);
                pixel_q.push_back(rand_pixel(d));
            end
            if (ph == 5) begin
                // sink holds off long while the source keeps offering
                sink_hold = 1'b1;
                wait (hold_count >= LONG_HOLD);
                sink_hold = 1'b0;
            end
            if (ph == 9) begin
                // source waits for every result to come back
                while (pixel_q.size() > 40) @(posedge i_clk);
                src_pause = 1'b1;
                while (fogged_q.size() > 0 || s_axis_tvalid) @(posedge i_clk);
                src_pause = 1'b0;
            end
            drain();
        end

        if (fail_count == 0)
            $display("distance_fog_factor_blend_tb: PASS");
        else
            $display("distance_fog_factor_blend_tb: FAIL");
        $finish;
    end

endmodule
